// ===== src/tmpg_pkg.sv =====
`timescale 1ns / 1ps

package tmpg_pkg;

    // Track count and field widths fixed by the register map
    localparam int MAX_TRACKS  = 4;
    localparam int MASK_W      = 4;
    localparam int GAIN_W      = 16;
    localparam int PAN_W       = 16;
    localparam int PGAIN_W     = 15;
    localparam int GP_W        = GAIN_W + PGAIN_W;
    localparam int ROUND_SHIFT = 26;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MUTE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOLO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MONO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAN    = 3'd5;

    localparam logic [MASK_W-1:0]     TRACK_BITS  = MASK_W'((1 << MAX_TRACKS) - 1);
    localparam logic [2:0]            TRACK_LIMIT = 3'(MAX_TRACKS);
    localparam logic signed [PAN_W-1:0] PAN_ONE     = 16'sd16384;
    localparam logic signed [PAN_W-1:0] PAN_NEG_ONE = -16'sd16384;
    localparam logic [CFG_DATA_W-1:0] GAIN_RESET  = 64'h1000_1000_1000_1000;

    typedef struct packed {
        logic load;
        logic gain;
        logic mult;
        logic acc;
        logic emit;
    } tmpg_cmd_t;

    typedef struct packed {
        logic last;
    } tmpg_status_t;

endpackage

// ===== src/track_mixer_pan_gain_solo.sv =====
`timescale 1ns / 1ps

// Four-track mixer with linear pan, Q4.12 track gain, mute and solo. Each input
// transaction is one sample frame of one track; the frame's mix comes out,
// saturated to SAMPLE_BITS, on the transaction flagged last_track. A track
// steps through capture, gain times pan gain, sample times gain, then round and
// accumulate, and a last track then loads the output register, waiting first
// if the previous mix has not been taken yet. Input is
// accepted again while a finished mix is still waiting on out_ready.
// Configuration writes land at once and are meant to happen between frames.
module track_mixer_pan_gain_solo #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tmpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmpg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      track_number,
    input  logic signed [SAMPLE_BITS-1:0]   sample_left,
    input  logic signed [SAMPLE_BITS-1:0]   sample_right,
    input  logic                            track_present,
    input  logic                            last_track,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_BITS-1:0]   mix_left,
    output logic signed [SAMPLE_BITS-1:0]   mix_right,
    output logic                            clipped
);
    import tmpg_pkg::*;

    tmpg_cmd_t    cmd;
    tmpg_status_t status;

    tmpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tmpg_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .track_number  (track_number),
        .sample_left   (sample_left),
        .sample_right  (sample_right),
        .track_present (track_present),
        .last_track    (last_track),
        .cmd           (cmd),
        .status        (status),
        .mix_left      (mix_left),
        .mix_right     (mix_right),
        .clipped       (clipped)
    );

endmodule

// ===== src/tmpg_ctrl.sv =====
`timescale 1ns / 1ps

module tmpg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  tmpg_pkg::tmpg_status_t status,
    output tmpg_pkg::tmpg_cmd_t    cmd
);
    import tmpg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GAIN = 5'b00010,
        S_MULT = 5'b00100,
        S_ACC  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg & ~out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/tmpg_datapath.sv =====
`timescale 1ns / 1ps

module tmpg_datapath #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tmpg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmpg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                          track_number,
    input  logic signed [SAMPLE_BITS-1:0]       sample_left,
    input  logic signed [SAMPLE_BITS-1:0]       sample_right,
    input  logic                                track_present,
    input  logic                                last_track,
    input  tmpg_pkg::tmpg_cmd_t                 cmd,
    output tmpg_pkg::tmpg_status_t              status,
    output logic signed [SAMPLE_BITS-1:0]       mix_left,
    output logic signed [SAMPLE_BITS-1:0]       mix_right,
    output logic                                clipped
);
    import tmpg_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + GP_W + 1;
    localparam int ACC_W  = SAMPLE_BITS + 20;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (ROUND_SHIFT - 1));
    localparam logic signed [ACC_W-1:0]  SAT_HI =
        {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  SAT_LO = ~SAT_HI;

    // Configuration
    logic [MASK_W-1:0]     mute_mask_reg;
    logic [MASK_W-1:0]     solo_mask_reg;
    logic [MASK_W-1:0]     mono_mask_reg;
    logic                  mix_stereo_reg;
    logic [CFG_DATA_W-1:0] gain_word_reg;
    logic [CFG_DATA_W-1:0] pan_word_reg;

    // Captured transaction
    logic [1:0]                    track_reg;
    logic signed [SAMPLE_BITS-1:0] sl_reg;
    logic signed [SAMPLE_BITS-1:0] sr_reg;
    logic                          present_reg;
    logic                          last_reg;

    // Gain stage
    logic [GP_W-1:0]               gpl_reg;
    logic [GP_W-1:0]               gpr_reg;
    logic signed [SAMPLE_BITS-1:0] sr_sel_reg;
    logic                          en_left_reg;
    logic                          en_right_reg;

    // Product stage
    logic signed [PROD_W-1:0] prod_left_reg;
    logic signed [PROD_W-1:0] prod_right_reg;

    logic signed [ACC_W-1:0] acc_left_reg;
    logic signed [ACC_W-1:0] acc_left_next;
    logic signed [ACC_W-1:0] acc_right_reg;
    logic signed [ACC_W-1:0] acc_right_next;

    logic signed [SAMPLE_BITS-1:0] mix_left_reg;
    logic signed [SAMPLE_BITS-1:0] mix_right_reg;
    logic                          clipped_reg;

    // Gain stage logic
    logic                    in_range;
    logic                    solo_any;
    logic                    audible;
    logic                    mono_trk;
    logic [GAIN_W-1:0]       gain_sel;
    logic signed [PAN_W-1:0] pan_raw;
    logic signed [PAN_W-1:0] pan_c;
    logic signed [PAN_W-1:0] pl_full;
    logic signed [PAN_W-1:0] pr_full;
    logic [PGAIN_W-1:0]      pl_val;
    logic [PGAIN_W-1:0]      pr_val;

    // Product and accumulate logic
    logic signed [GP_W:0]     gpl_s;
    logic signed [GP_W:0]     gpr_s;
    logic signed [PROD_W-1:0] prod_left_next;
    logic signed [PROD_W-1:0] prod_right_next;
    logic signed [PROD_W-1:0] biased_left;
    logic signed [PROD_W-1:0] biased_right;
    logic signed [PROD_W-1:0] shifted_left;
    logic signed [PROD_W-1:0] shifted_right;

    logic                          clip_left;
    logic                          clip_right;
    logic signed [SAMPLE_BITS-1:0] sat_left;
    logic signed [SAMPLE_BITS-1:0] sat_right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_mask_reg  <= '0;
            solo_mask_reg  <= '0;
            mono_mask_reg  <= '0;
            mix_stereo_reg <= 1'b1;
            gain_word_reg  <= GAIN_RESET;
            pan_word_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MUTE:   mute_mask_reg  <= cfg_data[MASK_W-1:0];
                REG_SOLO:   solo_mask_reg  <= cfg_data[MASK_W-1:0];
                REG_MONO:   mono_mask_reg  <= cfg_data[MASK_W-1:0];
                REG_STEREO: mix_stereo_reg <= cfg_data[0];
                REG_GAIN:   gain_word_reg  <= cfg_data;
                REG_PAN:    pan_word_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        in_range = ({1'b0, track_reg} < TRACK_LIMIT);
        solo_any = |(solo_mask_reg & TRACK_BITS);
        audible  = present_reg && in_range && !mute_mask_reg[track_reg] &&
                   (!solo_any || solo_mask_reg[track_reg]);
        mono_trk = mono_mask_reg[track_reg];
        gain_sel = gain_word_reg[{track_reg, 4'b0000} +: GAIN_W];
        pan_raw  = pan_word_reg[{track_reg, 4'b0000} +: PAN_W];

        if (pan_raw > PAN_ONE)
            pan_c = PAN_ONE;
        else if (pan_raw < PAN_NEG_ONE)
            pan_c = PAN_NEG_ONE;
        else
            pan_c = pan_raw;

        // linear law: near side stays at unity, far side falls to zero
        pl_full = (mix_stereo_reg && pan_c > 0) ? PAN_ONE - pan_c : PAN_ONE;
        pr_full = (mix_stereo_reg && pan_c < 0) ? PAN_ONE + pan_c : PAN_ONE;
        pl_val  = pl_full[PGAIN_W-1:0];
        pr_val  = pr_full[PGAIN_W-1:0];
    end

    always_comb
    begin
        gpl_s           = {1'b0, gpl_reg};
        gpr_s           = {1'b0, gpr_reg};
        prod_left_next  = PROD_W'(sl_reg) * PROD_W'(gpl_s);
        prod_right_next = PROD_W'(sr_sel_reg) * PROD_W'(gpr_s);

        // round half up, then drop the Q.41 fraction down to Q1.15
        biased_left   = prod_left_reg + ROUND_HALF;
        biased_right  = prod_right_reg + ROUND_HALF;
        shifted_left  = biased_left >>> ROUND_SHIFT;
        shifted_right = biased_right >>> ROUND_SHIFT;

        acc_left_next  = acc_left_reg;
        acc_right_next = acc_right_reg;
        if (cmd.emit)
        begin
            acc_left_next  = '0;
            acc_right_next = '0;
        end
        else if (cmd.acc)
        begin
            if (en_left_reg)
                acc_left_next = acc_left_reg + ACC_W'(shifted_left);
            if (en_right_reg)
                acc_right_next = acc_right_reg + ACC_W'(shifted_right);
        end
    end

    always_comb
    begin
        clip_left  = (acc_left_reg > SAT_HI) || (acc_left_reg < SAT_LO);
        clip_right = (acc_right_reg > SAT_HI) || (acc_right_reg < SAT_LO);

        if (acc_left_reg > SAT_HI)
            sat_left = SAT_HI[SAMPLE_BITS-1:0];
        else if (acc_left_reg < SAT_LO)
            sat_left = SAT_LO[SAMPLE_BITS-1:0];
        else
            sat_left = acc_left_reg[SAMPLE_BITS-1:0];

        if (acc_right_reg > SAT_HI)
            sat_right = SAT_HI[SAMPLE_BITS-1:0];
        else if (acc_right_reg < SAT_LO)
            sat_right = SAT_LO[SAMPLE_BITS-1:0];
        else
            sat_right = acc_right_reg[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            track_reg   <= track_number;
            sl_reg      <= sample_left;
            sr_reg      <= sample_right;
            present_reg <= track_present;
            last_reg    <= last_track;
        end
        if (cmd.gain)
        begin
            gpl_reg      <= GP_W'(gain_sel) * GP_W'(pl_val);
            gpr_reg      <= GP_W'(gain_sel) * GP_W'(pr_val);
            sr_sel_reg   <= mono_trk ? sl_reg : sr_reg;
            en_left_reg  <= audible;
            en_right_reg <= audible && mix_stereo_reg;
        end
        if (cmd.mult)
        begin
            prod_left_reg  <= prod_left_next;
            prod_right_reg <= prod_right_next;
        end
        if (cmd.emit)
        begin
            mix_left_reg  <= sat_left;
            mix_right_reg <= mix_stereo_reg ? sat_right : '0;
            clipped_reg   <= clip_left || (mix_stereo_reg && clip_right);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_left_reg  <= '0;
            acc_right_reg <= '0;
        end
        else
        begin
            acc_left_reg  <= acc_left_next;
            acc_right_reg <= acc_right_next;
        end
    end

    assign status.last = last_reg;
    assign mix_left    = mix_left_reg;
    assign mix_right   = mix_right_reg;
    assign clipped     = clipped_reg;

endmodule

// ===== src/tmpg_checker.sv =====
`timescale 1ns / 1ps

module tmpg_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] mix_left,
    input logic signed [SAMPLE_BITS-1:0] mix_right,
    input logic                          clipped
);

    localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = ~SAT_HI;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("mix dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(mix_left) && $stable(mix_right) && $stable(clipped))
        else $error("mix changed while stalled");

    // one transaction in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous transaction still in work");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("mix appeared without a finishing transaction");

    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> mix_left == SAT_HI || mix_left == SAT_LO ||
                                 mix_right == SAT_HI || mix_right == SAT_LO)
        else $error("clip flagged without a channel at a rail");

endmodule

bind track_mixer_pan_gain_solo tmpg_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mix_left  (mix_left),
    .mix_right (mix_right),
    .clipped   (clipped)
);
